// ----- rtl/core/ght_pkg.sv -----
// Shared constants, types and register codes of the gradient hysteresis threshold block.
`default_nettype none
package ght_pkg;
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;

  localparam int PIX_W    = 8;
  localparam int CLS_W    = 2;
  localparam int THR_W    = 9;
  localparam int WID_W    = 11;
  localparam int HGT_W    = 13;
  localparam int COL_W    = $clog2(MaxWidth);
  localparam int ROW_W    = HGT_W;
  localparam int RING_W   = 2;
  localparam int ADDR_W   = COL_W + RING_W;
  localparam int SQ_W     = 16;
  localparam int SUM_W    = SQ_W + 1;
  localparam int TS_SQ_W  = 2 * THR_W + 1;
  localparam int TW_SQ_W  = 2 * THR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = HGT_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRONG_THR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEAK_THR     = 2'd3;

  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(MaxWidth);
  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(MaxHeight);
  localparam logic [THR_W-1:0] STRONG_RST = 9'd100;
  localparam logic [THR_W-1:0] WEAK_RST   = 9'd50;
  localparam logic [WID_W-1:0] WIDTH_MIN  = 11'd3;
  localparam logic [HGT_W-1:0] HEIGHT_MIN = 13'd3;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  typedef enum logic [CLS_W-1:0] {
    CLS_OFF    = 2'd0,
    CLS_WEAK   = 2'd1,
    CLS_STRONG = 2'd2
  } class_e;

  typedef struct packed {
    logic [WID_W-1:0] w;
    logic [HGT_W-1:0] h;
  } geom_t;

  typedef struct packed {
    logic last;
  } task_t;
endpackage
`default_nettype wire

// ----- rtl/core/ght_ram.sv -----
// Simple dual-port RAM with registered read data.
`default_nettype none
module ght_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);
  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/core/ght_task_queue.sv -----
// Two-entry request queue between the classifier and the output stage.
`default_nettype none
module ght_task_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ght_pkg::task_t data_i,
  output logic                full_o,
  output logic                valid_o,
  output ght_pkg::task_t      data_o,
  input  wire logic           pop_i
);
  ght_pkg::task_t data_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = data_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q    <= 1'b0;
      rptr_q    <= 1'b0;
      cnt_q     <= 2'd0;
      data_q[0] <= '0;
      data_q[1] <= '0;
    end else begin
      if (push_i && !full_o) begin
        data_q[wptr_q] <= data_i;
        wptr_q         <= ~wptr_q;
      end
      if (pop_i && valid_o) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && valid_o};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("request queue count out of range");
endmodule
`default_nettype wire

// ----- rtl/core/ght_front.sv -----
// Front stage: accepts pixels, forms gradients and writes pixel classes.
`default_nettype none
module ght_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [ght_pkg::PIX_W-1:0]  pixel_in_i,
  input  wire logic                       is_fill_i,
  input  wire ght_pkg::geom_t             geom_i,
  input  wire logic [ght_pkg::THR_W-1:0]  strong_i,
  input  wire logic [ght_pkg::THR_W-1:0]  weak_i,
  input  wire logic                       restart_i,
  output logic                            task_push_o,
  output ght_pkg::task_t                  task_o,
  input  wire logic                       task_full_i,
  output logic                            cls_we_o,
  output logic [ght_pkg::ADDR_W-1:0]      cls_waddr_o,
  output logic [ght_pkg::CLS_W-1:0]       cls_wdata_o
);
  typedef enum logic [2:0] {F_IDLE, F_UP, F_LEFT, F_RIGHT, F_CLASS} fstate_e;

  fstate_e                        state_q;
  logic [ght_pkg::COL_W-1:0]      col_q, cur_col_q;
  logic [ght_pkg::ROW_W-1:0]      row_q, cur_row_q;
  logic [ght_pkg::PIX_W-1:0]      pix_q, up_q, left_q;
  logic                           emit_q, last_q;
  logic [ght_pkg::SQ_W-1:0]       sqv_q, sqh_q;
  logic [ght_pkg::TS_SQ_W-1:0]    ts_sq_q;
  logic [ght_pkg::TW_SQ_W-1:0]    tw_sq_q;

  logic                           accept, leave, col_last, in_frame, item_last, emit_in;
  logic                           interior;
  logic [ght_pkg::WID_W-1:0]      wm1;
  logic [ght_pkg::HGT_W-1:0]      hp2;
  logic [ght_pkg::PIX_W-1:0]      pix_wdata, pix_rdata;
  logic [ght_pkg::ADDR_W-1:0]     pix_waddr, pix_raddr;
  logic signed [ght_pkg::PIX_W:0] dv, dh;
  logic signed [2*ght_pkg::PIX_W+1:0] sv, sh;
  logic [ght_pkg::SUM_W-1:0]      sum;
  logic [ght_pkg::THR_W:0]        strong_p1;
  logic [2*ght_pkg::THR_W+1:0]    ts_full;
  logic [2*ght_pkg::THR_W-1:0]    tw_full;
  ght_pkg::class_e                cls;

  assign full      = state_q != F_IDLE;
  assign accept    = push && !full;
  assign wm1       = geom_i.w - 11'd1;
  assign hp2       = geom_i.h + 13'd2;
  assign col_last  = {1'b0, col_q} == wm1;
  assign in_frame  = row_q < geom_i.h;
  assign item_last = (row_q == hp2) && (col_q == '0);
  assign emit_in   = (row_q > 13'd2) || ((row_q == 13'd2) && (col_q != '0));

  assign pix_waddr = {row_q[ght_pkg::RING_W-1:0], col_q};
  assign pix_wdata = (is_fill_i || !in_frame) ? '0 : pixel_in_i;

  always_comb begin
    case (state_q)
      F_UP:    pix_raddr = {cur_row_q[ght_pkg::RING_W-1:0] - 2'd1, cur_col_q - 10'd1};
      F_LEFT:  pix_raddr = {cur_row_q[ght_pkg::RING_W-1:0] - 2'd1, cur_col_q + 10'd1};
      default: pix_raddr = {row_q[ght_pkg::RING_W-1:0] - 2'd2, col_q};
    endcase
  end

  ght_ram #(.DATA_W(ght_pkg::PIX_W), .ADDR_W(ght_pkg::ADDR_W)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (pix_waddr),
    .wdata_i (pix_wdata),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  assign dv        = $signed({1'b0, pix_q}) - $signed({1'b0, up_q});
  assign dh        = $signed({1'b0, pix_rdata}) - $signed({1'b0, left_q});
  assign sv        = dv * dv;
  assign sh        = dh * dh;
  assign sum       = {1'b0, sqv_q} + {1'b0, sqh_q};
  assign strong_p1 = {1'b0, strong_i} + 10'd1;
  assign ts_full   = strong_p1 * strong_p1;
  assign tw_full   = weak_i * weak_i;

  assign interior = (cur_row_q >= 13'd2) && (cur_row_q < geom_i.h) &&
                    (cur_col_q != '0) && ({1'b0, cur_col_q} < wm1);

  always_comb begin
    if (!interior) begin
      cls = ght_pkg::CLS_OFF;
    end else if ({2'b00, sum} >= ts_sq_q) begin
      cls = ght_pkg::CLS_STRONG;
    end else if ({1'b0, sum} < tw_sq_q) begin
      cls = ght_pkg::CLS_OFF;
    end else begin
      cls = ght_pkg::CLS_WEAK;
    end
  end

  assign leave       = (state_q == F_CLASS) && (!emit_q || !task_full_i);
  assign cls_we_o    = leave;
  assign cls_wdata_o = cls;
  assign cls_waddr_o = (cur_row_q == '0) ? {cur_row_q[ght_pkg::RING_W-1:0], cur_col_q}
                                         : {cur_row_q[ght_pkg::RING_W-1:0] - 2'd1, cur_col_q};
  assign task_push_o = leave && emit_q;
  assign task_o.last = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      cur_col_q <= '0;
      cur_row_q <= '0;
      pix_q     <= '0;
      up_q      <= '0;
      left_q    <= '0;
      emit_q    <= 1'b0;
      last_q    <= 1'b0;
      sqv_q     <= '0;
      sqh_q     <= '0;
      ts_sq_q   <= '0;
      tw_sq_q   <= '0;
    end else begin
      ts_sq_q <= ts_full[ght_pkg::TS_SQ_W-1:0];
      tw_sq_q <= tw_full;
      if (restart_i) begin
        col_q <= '0;
        row_q <= '0;
      end
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            cur_col_q <= col_q;
            cur_row_q <= row_q;
            pix_q     <= pix_wdata;
            emit_q    <= emit_in;
            last_q    <= item_last;
            if (item_last) begin
              col_q <= '0;
              row_q <= '0;
            end else if (col_last) begin
              col_q <= '0;
              row_q <= row_q + 13'd1;
            end else begin
              col_q <= col_q + 10'd1;
            end
            state_q <= F_UP;
          end
        end
        F_UP: begin
          up_q    <= pix_rdata;
          state_q <= F_LEFT;
        end
        F_LEFT: begin
          left_q  <= pix_rdata;
          state_q <= F_RIGHT;
        end
        F_RIGHT: begin
          sqv_q   <= sv[ght_pkg::SQ_W-1:0];
          sqh_q   <= sh[ght_pkg::SQ_W-1:0];
          state_q <= F_CLASS;
        end
        F_CLASS: begin
          if (leave) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) task_push_o |-> !task_full_i)
    else $error("request pushed into a full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == F_UP) && (cur_col_q == $past(col_q)))
    else $error("accepted pixel not captured");
endmodule
`default_nettype wire

// ----- rtl/core/ght_back.sv -----
// Back stage: reads the class window, applies hysteresis and buffers results.
`default_nettype none
module ght_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ght_pkg::geom_t             geom_i,
  input  wire logic                       restart_i,
  input  wire logic                       task_valid_i,
  input  wire ght_pkg::task_t             task_i,
  output logic                            task_pop_o,
  output logic [ght_pkg::ADDR_W-1:0]      cls_raddr_o,
  input  wire logic [ght_pkg::CLS_W-1:0]  cls_rdata_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [ght_pkg::PIX_W-1:0]       pixel_out_o,
  output logic                            frame_last_o
);
  typedef enum logic [1:0] {B_IDLE, B_READ, B_PUSH} bstate_e;

  bstate_e                    state_q;
  logic [ght_pkg::COL_W-1:0]  ocol_q;
  logic [ght_pkg::ROW_W-1:0]  orow_q;
  logic [1:0]                 kr_q, kc_q;
  logic                       idone_q, rvalid_q, rctr_q, found_q;
  logic [ght_pkg::CLS_W-1:0]  centre_q;
  logic [ght_pkg::PIX_W-1:0]  ob_pix_q [2];
  logic                       ob_last_q [2];
  logic                       ob_wptr_q, ob_rptr_q;
  logic [1:0]                 ob_cnt_q;

  logic [ght_pkg::WID_W-1:0]  wm1;
  logic [ght_pkg::HGT_W-1:0]  hm1;
  logic                       interior, ob_push, ob_pop, col_last;
  logic [ght_pkg::PIX_W-1:0]  value;

  assign wm1      = geom_i.w - 11'd1;
  assign hm1      = geom_i.h - 13'd1;
  assign col_last = {1'b0, ocol_q} == wm1;
  assign interior = (orow_q != '0) && (orow_q < hm1) &&
                    (ocol_q != '0) && ({1'b0, ocol_q} < wm1);

  assign cls_raddr_o = {orow_q[ght_pkg::RING_W-1:0] - 2'd1 + kr_q,
                        ocol_q - 10'd1 + {8'd0, kc_q}};

  always_comb begin
    case (centre_q)
      ght_pkg::CLS_STRONG: value = ght_pkg::EDGE_ON;
      ght_pkg::CLS_WEAK:   value = found_q ? ght_pkg::EDGE_ON : ght_pkg::EDGE_OFF;
      default:             value = ght_pkg::EDGE_OFF;
    endcase
  end

  assign ob_push     = (state_q == B_PUSH) && (ob_cnt_q != 2'd2);
  assign task_pop_o  = ob_push;
  assign ob_pop      = pop && !empty;
  assign empty       = ob_cnt_q == 2'd0;
  assign pixel_out_o = ob_pix_q[ob_rptr_q];
  assign frame_last_o = ob_last_q[ob_rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      ocol_q       <= '0;
      orow_q       <= '0;
      kr_q         <= '0;
      kc_q         <= '0;
      idone_q      <= 1'b0;
      rvalid_q     <= 1'b0;
      rctr_q       <= 1'b0;
      found_q      <= 1'b0;
      centre_q     <= ght_pkg::CLS_OFF;
      ob_pix_q[0]  <= '0;
      ob_pix_q[1]  <= '0;
      ob_last_q[0] <= 1'b0;
      ob_last_q[1] <= 1'b0;
      ob_wptr_q    <= 1'b0;
      ob_rptr_q    <= 1'b0;
      ob_cnt_q     <= 2'd0;
    end else begin
      if (restart_i) begin
        ocol_q <= '0;
        orow_q <= '0;
      end
      case (state_q)
        B_IDLE: begin
          found_q  <= 1'b0;
          centre_q <= ght_pkg::CLS_OFF;
          kr_q     <= '0;
          kc_q     <= '0;
          idone_q  <= 1'b0;
          rvalid_q <= 1'b0;
          if (task_valid_i) begin
            state_q <= interior ? B_READ : B_PUSH;
          end
        end
        B_READ: begin
          if (rvalid_q) begin
            if (cls_rdata_i == ght_pkg::CLS_STRONG) begin
              found_q <= 1'b1;
            end
            if (rctr_q) begin
              centre_q <= cls_rdata_i;
            end
          end
          if (idone_q) begin
            rvalid_q <= 1'b0;
            state_q  <= B_PUSH;
          end else begin
            rvalid_q <= 1'b1;
            rctr_q   <= (kr_q == 2'd1) && (kc_q == 2'd1);
            if (kc_q == 2'd2) begin
              kc_q <= '0;
              kr_q <= kr_q + 2'd1;
              if (kr_q == 2'd2) begin
                idone_q <= 1'b1;
              end
            end else begin
              kc_q <= kc_q + 2'd1;
            end
          end
        end
        B_PUSH: begin
          if (ob_push) begin
            ob_pix_q[ob_wptr_q]  <= value;
            ob_last_q[ob_wptr_q] <= task_i.last;
            ob_wptr_q            <= ~ob_wptr_q;
            if (task_i.last) begin
              ocol_q <= '0;
              orow_q <= '0;
            end else if (col_last) begin
              ocol_q <= '0;
              orow_q <= orow_q + 13'd1;
            end else begin
              ocol_q <= ocol_q + 10'd1;
            end
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
      if (ob_pop) begin
        ob_rptr_q <= ~ob_rptr_q;
      end
      ob_cnt_q <= ob_cnt_q + {1'b0, ob_push} - {1'b0, ob_pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) task_pop_o |-> task_valid_i)
    else $error("result produced without a request");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ob_cnt_q <= 2'd2)
    else $error("result buffer count out of range");
endmodule
`default_nettype wire

// ----- rtl/core/gradient_hysteresis_threshold.sv -----
// Top level: configuration registers, class line RAM, front and back stages.
// Output order: the result of pixel p waits for input item p + 2*width + 1; the front then
// reads the pixel window, squares and classifies, and the back reads the class window.
// Front: takes an item only while idle; three reads on the pixel RAM port, square, classify.
// Back: one request at a time; nine class RAM reads for an interior result, none for a border one.
// Reset: asynchronous, active low; counters and queues clear, registers take their defaults.
`default_nettype none
module gradient_hysteresis_threshold (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [ght_pkg::PIX_W-1:0]       pixel_in_i,
  input  wire logic                            is_fill_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [ght_pkg::PIX_W-1:0]            pixel_out_o,
  output logic                                 frame_last_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ght_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ght_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  logic [ght_pkg::WID_W-1:0]  width_q;
  logic [ght_pkg::HGT_W-1:0]  height_q;
  logic [ght_pkg::THR_W-1:0]  strong_q, weak_q;
  ght_pkg::geom_t             geom;
  logic                       restart;
  logic                       task_push, task_full, task_valid, task_pop;
  ght_pkg::task_t             task_in, task_out;
  logic                       cls_we;
  logic [ght_pkg::ADDR_W-1:0] cls_waddr, cls_raddr;
  logic [ght_pkg::CLS_W-1:0]  cls_wdata, cls_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ght_pkg::WIDTH_RST;
      height_q <= ght_pkg::HEIGHT_RST;
      strong_q <= ght_pkg::STRONG_RST;
      weak_q   <= ght_pkg::WEAK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ght_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[ght_pkg::WID_W-1:0];
        ght_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        ght_pkg::REG_STRONG_THR:   strong_q <= cfg_data_i[ght_pkg::THR_W-1:0];
        ght_pkg::REG_WEAK_THR:     weak_q   <= cfg_data_i[ght_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && ((cfg_idx_i == ght_pkg::REG_IMAGE_WIDTH) ||
                                (cfg_idx_i == ght_pkg::REG_IMAGE_HEIGHT));

  always_comb begin
    if (width_q < ght_pkg::WIDTH_MIN) begin
      geom.w = ght_pkg::WIDTH_MIN;
    end else if (width_q > ght_pkg::WIDTH_RST) begin
      geom.w = ght_pkg::WIDTH_RST;
    end else begin
      geom.w = width_q;
    end
    if (height_q < ght_pkg::HEIGHT_MIN) begin
      geom.h = ght_pkg::HEIGHT_MIN;
    end else if (height_q > ght_pkg::HEIGHT_RST) begin
      geom.h = ght_pkg::HEIGHT_RST;
    end else begin
      geom.h = height_q;
    end
  end

  ght_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .pixel_in_i  (pixel_in_i),
    .is_fill_i   (is_fill_i),
    .geom_i      (geom),
    .strong_i    (strong_q),
    .weak_i      (weak_q),
    .restart_i   (restart),
    .task_push_o (task_push),
    .task_o      (task_in),
    .task_full_i (task_full),
    .cls_we_o    (cls_we),
    .cls_waddr_o (cls_waddr),
    .cls_wdata_o (cls_wdata)
  );

  ght_task_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (task_push),
    .data_i  (task_in),
    .full_o  (task_full),
    .valid_o (task_valid),
    .data_o  (task_out),
    .pop_i   (task_pop)
  );

  ght_ram #(.DATA_W(ght_pkg::CLS_W), .ADDR_W(ght_pkg::ADDR_W)) u_cls_ram (
    .clk_i   (clk_i),
    .we_i    (cls_we),
    .waddr_i (cls_waddr),
    .wdata_i (cls_wdata),
    .raddr_i (cls_raddr),
    .rdata_o (cls_rdata)
  );

  ght_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .restart_i    (restart),
    .task_valid_i (task_valid),
    .task_i       (task_out),
    .task_pop_o   (task_pop),
    .cls_raddr_o  (cls_raddr),
    .cls_rdata_i  (cls_rdata),
    .empty        (empty),
    .pop          (pop),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for gradient_hysteresis_threshold: directed and random frames checked against an edge predictor.
`timescale 1ns / 100ps
module tb;
  localparam int RingSize = 4 * ght_pkg::MaxWidth;
  localparam int PixW     = ght_pkg::PIX_W;
  localparam int ThrW     = ght_pkg::THR_W;
  localparam int CfgDataW = ght_pkg::CFG_DATA_W;

  typedef struct {
    logic [ght_pkg::PIX_W-1:0] pixel;
    logic                      fill;
  } pixel_req_t;

  typedef struct {
    logic [ght_pkg::PIX_W-1:0] value;
    logic                      last;
  } edge_res_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           push = 1'b0;
  logic                           full;
  logic [ght_pkg::PIX_W-1:0]      pixel_in_i = '0;
  logic                           is_fill_i = 1'b0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic [ght_pkg::PIX_W-1:0]      pixel_out_o;
  logic                           frame_last_o;
  logic                           cfg_we_i = 1'b0;
  logic [ght_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [ght_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  gradient_hysteresis_threshold dut (
    .clk_i, .rst_ni, .push, .full, .pixel_in_i, .is_fill_i,
    .empty, .pop, .pixel_out_o, .frame_last_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pixel_req_t  pixel_q[$];
  edge_res_t   edge_q[$];
  int unsigned errors = 0;
  int unsigned accepted = 0;
  bit          push_calm = 0;
  bit          pop_calm = 0;

  // predictor state
  logic [ght_pkg::WID_W-1:0] geo_w = ght_pkg::WIDTH_RST;
  logic [ght_pkg::HGT_W-1:0] geo_h = ght_pkg::HEIGHT_RST;
  logic [ght_pkg::THR_W-1:0] thr_strong = ght_pkg::STRONG_RST;
  logic [ght_pkg::THR_W-1:0] thr_weak = ght_pkg::WEAK_RST;
  logic [ght_pkg::PIX_W-1:0] pix_ring[RingSize];
  ght_pkg::class_e           cls_ring[RingSize];
  int unsigned               in_col = 0, in_row = 0, out_col = 0, out_row = 0;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int unsigned isqrt(int unsigned v);
    int unsigned r;
    r = 0;
    for (int b = 9; b >= 0; b--) begin
      if ((r | (1 << b)) * (r | (1 << b)) <= v) r = r | (1 << b);
    end
    return r;
  endfunction

  function automatic int unsigned geo_width();
    return (geo_w < ght_pkg::WIDTH_MIN) ? ght_pkg::WIDTH_MIN :
           (geo_w > ght_pkg::MaxWidth) ? ght_pkg::MaxWidth : geo_w;
  endfunction

  function automatic int unsigned geo_height();
    return (geo_h < ght_pkg::HEIGHT_MIN) ? ght_pkg::HEIGHT_MIN :
           (geo_h > ght_pkg::MaxHeight) ? ght_pkg::MaxHeight : geo_h;
  endfunction

  task automatic predict_edges(input logic [ght_pkg::PIX_W-1:0] px, input logic fl);
    int unsigned w, h, total, n, m, p, root, mr, mc, idx;
    int dv, dh;
    bit found;
    ght_pkg::class_e cls, centre;
    edge_res_t res;
    w = geo_width();
    h = geo_height();
    total = w * h;
    n = in_row * w + in_col;
    pix_ring[n % RingSize] = (fl || n >= total) ? '0 : px;
    if (in_row == 0) begin
      cls_ring[n % RingSize] = ght_pkg::CLS_OFF;
    end else begin
      m = n - w;
      mr = in_row - 1;
      mc = in_col;
      cls = ght_pkg::CLS_OFF;
      if (mr != 0 && mr < h - 1 && mc != 0 && mc < w - 1) begin
        dv = int'(pix_ring[(m + w) % RingSize]) - int'(pix_ring[(m - w) % RingSize]);
        dh = int'(pix_ring[(m + 1) % RingSize]) - int'(pix_ring[(m - 1) % RingSize]);
        root = isqrt(dv * dv + dh * dh);
        if (root > thr_strong) cls = ght_pkg::CLS_STRONG;
        else if (root < thr_weak) cls = ght_pkg::CLS_OFF;
        else cls = ght_pkg::CLS_WEAK;
      end
      cls_ring[m % RingSize] = cls;
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (n < 2 * w + 1) return;
    p = out_row * w + out_col;
    res.value = ght_pkg::EDGE_OFF;
    res.last = (p == total - 1);
    if (out_row != 0 && out_row < h - 1 && out_col != 0 && out_col < w - 1) begin
      found = 0;
      for (int k = 0; k < 9; k++) begin
        idx = p - w - 1 + (k / 3) * w + (k % 3);
        if (cls_ring[idx % RingSize] == ght_pkg::CLS_STRONG) found = 1;
      end
      centre = cls_ring[p % RingSize];
      if (centre == ght_pkg::CLS_STRONG || (centre == ght_pkg::CLS_WEAK && found)) begin
        res.value = ght_pkg::EDGE_ON;
      end
    end
    edge_q.push_back(res);
    if (res.last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin : drv
      int unsigned send_gap;
      pixel_req_t req;
      if (push && !full) begin
        predict_edges(pixel_in_i, is_fill_i);
        accepted++;
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        req = pixel_q.pop_front();
        push <= 1'b1;
        pixel_in_i <= req.pixel;
        is_fill_i <= req.fill;
        send_gap = push_calm ? 0 : gap_len();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin : mon
      int unsigned stall, hold;
      bit held;
      edge_res_t exp_res;
      if (pop && !empty) begin
        if (edge_q.size() == 0) begin
          $display("%0t: unexpected result pixel_out=%0d frame_last=%0b",
                   $realtime, pixel_out_o, frame_last_o);
          errors++;
        end else begin
          exp_res = edge_q.pop_front();
          if (pixel_out_o !== exp_res.value) begin
            $display("%0t: pixel_out expected %0d actual %0d",
                     $realtime, exp_res.value, pixel_out_o);
            errors++;
          end
          if (frame_last_o !== exp_res.last) begin
            $display("%0t: frame_last expected %0b actual %0b",
                     $realtime, exp_res.last, frame_last_o);
            errors++;
          end
        end
      end
      if (!held && accepted >= 700) begin
        held = 1;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        stall = pop_calm ? 0 : gap_len();
      end
    end
  end

  task automatic write_regs(input logic [ght_pkg::CFG_DATA_W-1:0] w_raw,
                            input logic [ght_pkg::CFG_DATA_W-1:0] h_raw,
                            input logic [ght_pkg::THR_W-1:0] s,
                            input logic [ght_pkg::THR_W-1:0] wk);
    logic [ght_pkg::CFG_DATA_W-1:0] vals[4];
    logic [ght_pkg::CFG_IDX_W-1:0] idxs[4];
    vals = '{w_raw, h_raw, CfgDataW'(s), CfgDataW'(wk)};
    idxs = '{ght_pkg::REG_IMAGE_WIDTH, ght_pkg::REG_IMAGE_HEIGHT,
             ght_pkg::REG_STRONG_THR, ght_pkg::REG_WEAK_THR};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idxs[i];
      cfg_data_i <= vals[i];
      case (idxs[i])
        ght_pkg::REG_IMAGE_WIDTH: begin
          geo_w = vals[i][ght_pkg::WID_W-1:0];
          in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        ght_pkg::REG_IMAGE_HEIGHT: begin
          geo_h = vals[i][ght_pkg::HGT_W-1:0];
          in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end
        ght_pkg::REG_STRONG_THR: thr_strong = vals[i][ght_pkg::THR_W-1:0];
        default: thr_weak = vals[i][ght_pkg::THR_W-1:0];
      endcase
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [ght_pkg::PIX_W-1:0] next_pixel(int style,
                                                           logic [ght_pkg::PIX_W-1:0] prev);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (style)
      0: return PixW'($urandom);
      1: begin
        if (r < 80) return prev;
        if (r < 88) return '0;
        if (r < 96) return '1;
        return PixW'($urandom);
      end
      default: return prev + PixW'($urandom_range(0, 6)) - PixW'(3);
    endcase
  endfunction

  // run one configured frame; a partial frame stops early
  task automatic run_frame(input logic [ght_pkg::CFG_DATA_W-1:0] w_raw,
                           input logic [ght_pkg::CFG_DATA_W-1:0] h_raw,
                           input logic [ght_pkg::THR_W-1:0] s,
                           input logic [ght_pkg::THR_W-1:0] wk,
                           input bit partial, input int style);
    int unsigned w, h, total, count;
    pixel_req_t req;
    logic [ght_pkg::PIX_W-1:0] prev;
    write_regs(w_raw, h_raw, s, wk);
    w = geo_width();
    h = geo_height();
    total = w * h;
    count = partial ? $urandom_range(1, total - 1) : total + 2 * w + 1;
    push_calm = ($urandom_range(0, 4) == 0);
    pop_calm = ($urandom_range(0, 4) == 0);
    prev = PixW'($urandom);
    for (int unsigned i = 0; i < count; i++) begin
      prev = next_pixel(style, prev);
      req.pixel = prev;
      req.fill = (i < total) ? ($urandom_range(0, 29) == 0) : ($urandom_range(0, 1) == 1);
      pixel_q.push_back(req);
    end
    do @(posedge clk_i); while (pixel_q.size() > 0 || push || edge_q.size() > 0);
    repeat (400) @(posedge clk_i);
  endtask

  initial begin
    #100ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned w, h;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: smallest frames, out-of-range geometry, threshold extremes
    run_frame(13'd3, 13'd3, 9'd0, 9'd0, 0, 0);
    run_frame(13'd0, 13'd0, 9'd511, 9'd0, 0, 1);
    run_frame(13'd2, 13'd1, 9'd0, 9'd511, 0, 0);
    run_frame(13'd4, 13'd3, 9'd100, 9'd50, 0, 1);
    run_frame(13'd5, 13'd4, 9'd30, 9'd60, 1, 0);
    // random frames
    while (accepted < 1700) begin
      w = $urandom_range(3, 14);
      h = $urandom_range(3, 12);
      run_frame(CfgDataW'(w), CfgDataW'(h), ThrW'($urandom_range(0, 400)),
                ThrW'($urandom_range(0, 300)), $urandom_range(0, 9) == 0,
                $urandom_range(0, 2));
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
